// ----- rtl/core/chs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package chs_pkg;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;
    localparam logic [CfgIdxW-1:0] CFG_RANGE_MIN = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_BIN_SCALE = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_BIN_WIDTH = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_BIN_COUNT = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_STRIDE = 3'd4;

    // one classified sample handed from front to back
    typedef struct packed {
        logic       hit;
        logic [5:0] bin;
        logic       dump;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_UPD,
        ST_DREAD,
        ST_DIV,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/core/cumulative_histogram_sweep_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Cumulative histogram of signed Q16.16 samples. A two-stage front computes
// the bin (one 33x32 multiply) and decides on dumps; a four-entry queue feeds
// the back, which reads and then updates the bin counter memory for each
// sample. A dump then reports every bin in use, each through a read, a
// restoring divide that forms the fraction one bit a cycle, and an output
// state that waits while the result side stalls. Counter memory is cleared
// at reset by valid bits.
module cumulative_histogram_sweep_unit #(
    parameter int unsigned MAX_BINS      = 64,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [31:0]              i_sample_value,
    input  wire logic                            i_cfg_we,
    input  wire logic [chs_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  wire logic [chs_pkg::CfgDataW-1:0]    i_cfg_data,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [5:0]                           o_bin_index,
    output logic signed [31:0]                   o_bin_center,
    output logic [31:0]                          o_samples_seen,
    output logic [FRACTION_BITS:0]               o_bin_fraction,
    output logic                                 o_last_bin
);
    import chs_pkg::*;

    logic signed [31:0] r_range_min;
    logic [31:0]        r_bin_scale;
    logic [31:0]        r_bin_width;
    logic [6:0]         r_bin_count;
    logic [23:0]        r_stride;
    logic               w_fv, w_fs, w_qv, w_qs;
    t_cmd               w_fcmd, w_qcmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= '0;
            r_bin_scale <= 32'd65536;
            r_bin_width <= 32'd65536;
            r_bin_count <= 7'd64;
            r_stride    <= 24'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RANGE_MIN: r_range_min <= i_cfg_data;
                CFG_BIN_SCALE: r_bin_scale <= i_cfg_data;
                CFG_BIN_WIDTH: r_bin_width <= i_cfg_data;
                CFG_BIN_COUNT: r_bin_count <= i_cfg_data[6:0];
                CFG_STRIDE:    r_stride    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    chs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_sample_value(i_sample_value), .i_range_min(r_range_min),
        .i_bin_scale(r_bin_scale),
        .i_nbins((r_bin_count > 7'(MAX_BINS)) ? 7'(MAX_BINS) : r_bin_count),
        .i_stride(r_stride), .o_valid(w_fv), .i_stall(w_fs), .o_cmd(w_fcmd)
    );

    chs_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_fv), .o_stall(w_fs),
        .i_cmd(w_fcmd), .o_valid(w_qv), .i_stall(w_qs), .o_cmd(w_qcmd)
    );

    chs_back #(.MAX_BINS(MAX_BINS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .o_stall(w_qs),
        .i_cmd(w_qcmd), .i_range_min(r_range_min), .i_bin_width(r_bin_width),
        .i_nbins(r_bin_count), .o_valid(o_valid), .i_stall(i_stall),
        .o_bin_index(o_bin_index), .o_bin_center(o_bin_center),
        .o_samples_seen(o_samples_seen), .o_bin_fraction(o_bin_fraction),
        .o_last_bin(o_last_bin)
    );
endmodule
`default_nettype wire

// ----- rtl/core/chs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module chs_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_sample_value,
    input  wire logic signed [31:0] i_range_min,
    input  wire logic        [31:0] i_bin_scale,
    input  wire logic        [6:0]  i_nbins,
    input  wire logic        [23:0] i_stride,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output chs_pkg::t_cmd           o_cmd
);
    import chs_pkg::*;

    // stage 1: difference, stage 2: product and compare
    logic        r_v1;
    logic [32:0] r_diff;
    logic        r_dump1;
    logic        r_v2;
    t_cmd        r_cmd;
    logic [23:0] r_scnt;
    logic [63:0] w_prod;
    logic [32:0] w_diff;
    logic [23:0] w_stride;
    logic        w_adv2;
    logic        w_adv1;
    logic        w_take;
    logic        w_dump;

    assign w_adv2   = !r_v2 || !i_stall;
    assign w_adv1   = !r_v1 || w_adv2;
    assign o_stall  = !w_adv1;
    assign w_take   = i_valid && w_adv1;
    assign w_diff   = {i_sample_value[31], i_sample_value} - {i_range_min[31], i_range_min};
    assign w_stride = (i_stride == 24'd0) ? 24'd1 : i_stride;
    assign w_dump   = ({1'b0, r_scnt} + 25'd1) >= {1'b0, w_stride};
    assign w_prod   = {31'd0, r_diff} * {32'd0, i_bin_scale};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_scnt <= '0;
        end else begin
            if (w_adv1) r_v1 <= w_take;
            if (w_adv2) r_v2 <= r_v1;
            if (w_take) r_scnt <= w_dump ? 24'd0 : r_scnt + 24'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_diff  <= w_diff;
            r_dump1 <= w_dump;
        end
        if (w_adv2 && r_v1) begin
            r_cmd.hit  <= !r_diff[32] && (w_prod[63:32] < {25'd0, i_nbins});
            r_cmd.bin  <= w_prod[37:32];
            r_cmd.dump <= r_dump1;
        end
    end

    assign o_valid = r_v2;
    assign o_cmd   = r_cmd;
endmodule
`default_nettype wire

// ----- rtl/core/chs_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module chs_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  chs_pkg::t_cmd      i_cmd,
    output logic               o_valid,
    input  wire logic          i_stall,
    output chs_pkg::t_cmd      o_cmd
);
    import chs_pkg::*;

    t_cmd       r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_stall = r_cnt[2];
    assign o_valid = r_cnt != 3'd0;
    assign w_push  = i_valid && !r_cnt[2];
    assign w_pop   = o_valid && !i_stall;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, w_push} - {2'd0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// ----- rtl/core/chs_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module chs_back #(
    parameter int unsigned MAX_BINS      = 64,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  chs_pkg::t_cmd                 i_cmd,
    input  wire logic signed [31:0]       i_range_min,
    input  wire logic        [31:0]       i_bin_width,
    input  wire logic        [6:0]        i_nbins,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [5:0]                    o_bin_index,
    output logic signed [31:0]            o_bin_center,
    output logic [31:0]                   o_samples_seen,
    output logic [FRACTION_BITS:0]        o_bin_fraction,
    output logic                          o_last_bin
);
    import chs_pkg::*;

    localparam int unsigned AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int unsigned NW  = 32 + FRACTION_BITS;
    localparam int unsigned QW  = FRACTION_BITS + 1;
    localparam int unsigned CW  = $clog2(NW + 1);

    t_state          r_st, n_st;
    logic [31:0]     r_mem [MAX_BINS];
    logic [MAX_BINS-1:0] r_vld;
    logic [31:0]     r_rd;
    logic            r_rdv;
    t_cmd            r_cmd;
    logic [31:0]     r_total;
    logic [6:0]      r_n;
    logic [NW-1:0]   r_num;
    logic [32:0]     r_rem;
    logic [CW-1:0]   r_step;
    logic [QW-1:0]   r_q;
    logic signed [39:0] r_cen;
    logic [38:0]     r_wacc;
    logic            r_ov;
    logic [5:0]      r_oi;
    logic signed [31:0] r_oc;
    logic [31:0]     r_os;
    logic [QW-1:0]   r_of;
    logic            r_ol;
    logic [AW-1:0]   w_addr;
    logic [AW-1:0]   w_nidx;
    logic [32:0]     w_rem_sh;
    logic [32:0]     w_sub;
    logic [31:0]     w_cnt;
    logic [6:0]      w_nb;
    logic signed [39:0] w_cen;

    assign w_nb     = (i_nbins > 7'(MAX_BINS)) ? 7'(MAX_BINS) : i_nbins;
    assign w_nidx   = r_n[AW-1:0];
    assign w_addr   = (r_st == ST_IDLE) ? i_cmd.bin[AW-1:0] :
                      (r_st == ST_RD)   ? r_cmd.bin[AW-1:0] : w_nidx;
    assign w_cnt    = r_rdv ? r_rd : 32'd0;
    assign w_rem_sh = {r_rem[31:0], r_num[NW-1]};
    assign w_sub    = w_rem_sh - {1'b0, r_total};
    // center = range_min + floor((2n+1)*w/2) = range_min + n*w + floor(w/2)
    assign w_cen    = $signed({{8{i_range_min[31]}}, i_range_min})
                    + $signed({2'b00, r_wacc[38:1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= ST_IDLE;
        else r_st <= n_st;
    end

    always_comb begin
        n_st    = r_st;
        o_stall = 1'b1;
        unique case (r_st)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) n_st = ST_RD;
            end
            ST_RD:   n_st = ST_UPD;
            ST_UPD:  n_st = (r_cmd.dump && w_nb != 7'd0) ? ST_DREAD : ST_IDLE;
            ST_DREAD: n_st = ST_DIV;
            ST_DIV:  if (r_step == CW'(QW)) n_st = ST_OUT;
            ST_OUT: begin
                if (!r_ov || !i_stall) n_st = (r_n + 7'd1 >= w_nb) ? ST_IDLE : ST_DREAD;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_total <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall) r_ov <= 1'b0;
            if (r_st == ST_UPD) begin
                if (r_total != 32'hFFFF_FFFF) r_total <= r_total + 32'd1;
                if (r_cmd.hit) r_vld[r_cmd.bin[AW-1:0]] <= 1'b1;
            end
            if (r_st == ST_OUT && (!r_ov || !i_stall)) r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd  <= r_mem[w_addr];
        r_rdv <= r_vld[w_addr];
        if (r_st == ST_IDLE && !o_stall && i_valid) r_cmd <= i_cmd;
        if (r_st == ST_UPD) begin
            r_n    <= '0;
            r_wacc <= {7'd0, i_bin_width};
            if (r_cmd.hit && w_cnt != 32'hFFFF_FFFF)
                r_mem[r_cmd.bin[AW-1:0]] <= w_cnt + 32'd1;
            else if (r_cmd.hit)
                r_mem[r_cmd.bin[AW-1:0]] <= w_cnt;
        end
        if (r_st == ST_DREAD) begin
            r_step <= '0;
            r_rem  <= '0;
            r_q    <= '0;
            r_cen  <= w_cen;
        end
        if (r_st == ST_DIV && r_step == '0) begin
            // skip leading quotient bits known to be zero (count <= total)
            r_rem  <= {2'b00, w_cnt[31:1]};
            r_num  <= {w_cnt[0], {(NW-1){1'b0}}};
            r_step <= r_step + CW'(1);
        end else if (r_st == ST_DIV) begin
            r_num  <= {r_num[NW-2:0], 1'b0};
            r_step <= r_step + CW'(1);
            r_rem  <= w_sub[32] ? w_rem_sh : w_sub;
            r_q    <= {r_q[QW-2:0], !w_sub[32]};
        end
        if (r_st == ST_OUT && (!r_ov || !i_stall)) begin
            r_oi   <= r_n[5:0];
            r_oc   <= (r_cen > 40'sh00_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                      (r_cen < -40'sh00_8000_0000) ? 32'sh8000_0000 : r_cen[31:0];
            r_os   <= r_total;
            r_of   <= r_q;
            r_ol   <= (r_n + 7'd1 >= w_nb);
            r_n    <= r_n + 7'd1;
            r_wacc <= r_wacc + {6'd0, i_bin_width, 1'b0};
        end
    end

    assign o_valid        = r_ov;
    assign o_bin_index    = r_oi;
    assign o_bin_center   = r_oc;
    assign o_samples_seen = r_os;
    assign o_bin_fraction = r_of;
    assign o_last_bin     = r_ol;
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import chs_pkg::*;

    typedef struct {
        logic [5:0]         index;
        logic signed [31:0] center;
        logic [31:0]        seen;
        logic [16:0]        fraction;
        logic               last;
    } t_hist_bin;

    class t_hist_scoreboard;
        logic signed [31:0] range_min;
        logic [31:0]        bin_scale;
        logic [31:0]        bin_width;
        logic [6:0]         bin_count;
        logic [23:0]        stride;
        logic [31:0]        counts[64];
        logic [31:0]        total;
        logic [23:0]        stride_cnt;
        t_hist_bin          dump_q[$];
        int                 errors;
        int                 matched;
        int                 dumps;

        function new();
            range_min = 0;
            bin_scale = 32'd65536;
            bin_width = 32'd65536;
            bin_count = 7'd64;
            stride = 24'd1;
            foreach (counts[i]) counts[i] = 0;
            total = 0;
            stride_cnt = 0;
            errors = 0;
            matched = 0;
            dumps = 0;
        endfunction

        function int bins_used();
            return (bin_count > 64) ? 64 : int'(bin_count);
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                CFG_RANGE_MIN: range_min = data;
                CFG_BIN_SCALE: bin_scale = data;
                CFG_BIN_WIDTH: bin_width = data;
                CFG_BIN_COUNT: bin_count = data[6:0];
                CFG_STRIDE:    stride = data[23:0];
                default: ;
            endcase
        endfunction

        // bin the sample, and on a stride boundary queue one entry per bin
        function void note_sample(logic signed [31:0] value);
            longint     diff;
            longint     centre;
            logic [63:0] prod;
            logic [63:0] frac;
            logic [24:0] eff;
            int          nb;
            t_hist_bin   r;
            nb = bins_used();
            diff = longint'(value) - longint'(range_min);
            if (diff >= 0) begin
                prod = 64'(diff) * 64'(bin_scale);
                if (prod[63:32] < nb && counts[prod[37:32]] != 32'hffffffff)
                    counts[prod[37:32]]++;
            end
            if (total != 32'hffffffff) total++;
            eff = (stride == 0) ? 25'd1 : 25'(stride);
            if (25'(stride_cnt) + 1 < eff) begin
                stride_cnt++;
                return;
            end
            stride_cnt = 0;
            dumps++;
            for (int n = 0; n < nb; n++) begin
                centre = longint'((64'(2 * n + 1) * 64'(bin_width)) >> 1)
                    + longint'(range_min);
                if (centre > 64'sd2147483647) centre = 64'sd2147483647;
                if (centre < -64'sd2147483648) centre = -64'sd2147483648;
                frac = (total == 0) ? 64'd0 : ({32'd0, counts[n]} << 16) / total;
                r.index = n[5:0];
                r.center = centre[31:0];
                r.seen = total;
                r.fraction = frac[16:0];
                r.last = (n + 1 == nb);
                dump_q.push_back(r);
            end
        endfunction

        function void check(t_hist_bin got);
            t_hist_bin exp_r;
            if (dump_q.size() == 0) begin
                $display("%0t: unexpected bin transfer, index %0d", $time, got.index);
                errors++;
                return;
            end
            exp_r = dump_q.pop_front();
            if (got.index !== exp_r.index) begin
                $display("%0t: bin_index exp %0d got %0d", $time, exp_r.index, got.index);
                errors++;
            end
            if (got.center !== exp_r.center) begin
                $display("%0t: bin_center exp %h got %h", $time, exp_r.center, got.center);
                errors++;
            end
            if (got.seen !== exp_r.seen) begin
                $display("%0t: samples_seen exp %0d got %0d", $time, exp_r.seen, got.seen);
                errors++;
            end
            if (got.fraction !== exp_r.fraction) begin
                $display("%0t: bin_fraction exp %h got %h", $time, exp_r.fraction,
                    got.fraction);
                errors++;
            end
            if (got.last !== exp_r.last) begin
                $display("%0t: last_bin exp %b got %b", $time, exp_r.last, got.last);
                errors++;
            end
            matched++;
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [31:0] i_sample_value;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               o_valid;
    logic               i_stall;
    logic [5:0]         o_bin_index;
    logic signed [31:0] o_bin_center;
    logic [31:0]        o_samples_seen;
    logic [16:0]        o_bin_fraction;
    logic               o_last_bin;

    t_hist_scoreboard sb;
    logic             no_idle;
    int               rx_wait;
    int               samples_sent;

    cumulative_histogram_sweep_unit uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_sample_value(i_sample_value),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_bin_index(o_bin_index),
        .o_bin_center(o_bin_center),
        .o_samples_seen(o_samples_seen),
        .o_bin_fraction(o_bin_fraction),
        .o_last_bin(o_last_bin)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("tb_top failed");
        $finish;
    end

    // result side: random stall per transfer
    initial begin
        t_hist_bin got;
        rx_wait = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.index = o_bin_index;
                got.center = o_bin_center;
                got.seen = o_samples_seen;
                got.fraction = o_bin_fraction;
                got.last = o_last_bin;
                sb.check(got);
                rx_wait = no_idle ? 0 : $urandom_range(0, 13);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            @(negedge i_clk);
            i_stall = (rx_wait > 0);
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_sample(input logic signed [31:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 13);
        i_valid = 1'b0;
        repeat (gap) @(negedge i_clk);
        i_valid = 1'b1;
        i_sample_value = v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_sample(v);
        samples_sent++;
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_reg(idx, data);
    endtask

    // let queued updates with no dump retire before touching registers
    task automatic wait_quiet();
        while (sb.dump_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mostly samples that land inside the bins in use
    function automatic logic signed [31:0] pick_sample();
        longint      span;
        longint      s;
        logic [63:0] r;
        int          nb;
        if ($urandom_range(0, 9) < 3) return $urandom;
        nb = sb.bins_used();
        if (sb.bin_scale == 0) span = 64'hffff_ffff;
        else span = longint'((64'(nb) << 32) / 64'(sb.bin_scale));
        if (span > 64'hffff_ffff) span = 64'hffff_ffff;
        r = {$urandom, $urandom};
        s = longint'(sb.range_min) + longint'(r % 64'(span + 1));
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        return s[31:0];
    endfunction

    initial begin
        logic [31:0] stride_v;
        sb = new();
        no_idle = 1'b0;
        samples_sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample_value = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (4) @(negedge i_clk);

        // reset settings: dump after every sample, top edge and below range dropped
        send_sample(32'sd0);
        send_sample(32'h003f_8000);
        send_sample(32'h0040_0000);
        send_sample(-32'sd1);
        wait_quiet();

        // bin count above the limit, stride zero, tiny scale, centers saturate
        write_reg(CFG_RANGE_MIN, 32'h8000_0000);
        write_reg(CFG_BIN_SCALE, 32'd1);
        write_reg(CFG_BIN_WIDTH, 32'hffff_ffff);
        write_reg(CFG_BIN_COUNT, 32'd127);
        write_reg(CFG_STRIDE, 32'd0);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        wait_quiet();

        // no bins in use: dumps give nothing
        write_reg(CFG_RANGE_MIN, 32'h7fff_ffff);
        write_reg(CFG_BIN_SCALE, 32'hffff_ffff);
        write_reg(CFG_BIN_WIDTH, 32'd0);
        write_reg(CFG_BIN_COUNT, 32'd0);
        write_reg(CFG_STRIDE, 32'd3);
        repeat (3) send_sample(32'h7fff_ffff);
        wait_quiet();

        // stride lowered while the counter is part way
        write_reg(CFG_BIN_COUNT, 32'd3);
        write_reg(CFG_RANGE_MIN, 32'hffff_0000);
        write_reg(CFG_BIN_SCALE, 32'h0001_0000);
        write_reg(CFG_BIN_WIDTH, 32'h0001_0000);
        write_reg(CFG_STRIDE, 32'd5);
        send_sample(32'hffff_8000);
        send_sample(32'h0000_4000);
        send_sample(32'h0001_ffff);
        wait_quiet();
        write_reg(CFG_STRIDE, 32'd2);
        send_sample(32'h0000_0000);
        wait_quiet();

        for (int ph = 0; ph < 6; ph++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            write_reg(CFG_RANGE_MIN, (ph == 5) ? 32'h8000_0000 : pick_word());
            write_reg(CFG_BIN_SCALE,
                ($urandom_range(0, 1) != 0) ? (32'h1_0000 << $urandom_range(0, 8))
                                            : pick_word());
            write_reg(CFG_BIN_WIDTH, pick_word());
            case ($urandom_range(0, 5))
                0: write_reg(CFG_BIN_COUNT, (ph % 2 == 0) ? 32'd64 : 32'd127);
                1: write_reg(CFG_BIN_COUNT, 32'd1);
                default: write_reg(CFG_BIN_COUNT, $urandom_range(2, 8));
            endcase
            case ($urandom_range(0, 7))
                0: stride_v = 32'd0;
                1: stride_v = 32'h00ff_ffff;
                default: stride_v = $urandom_range(1, 6);
            endcase
            write_reg(CFG_STRIDE, stride_v);
            repeat (32) send_sample(pick_sample());
            // hold off the sender until the block has caught up
            if (ph == 2) begin
                while (sb.dump_q.size() != 0) @(negedge i_clk);
            end
            wait_quiet();
        end

        no_idle = 1'b0;
        while (sb.dump_q.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        $display("%0d samples over reset, edge and random settings; %0d dumps, %0d bins checked",
            samples_sent, sb.dumps, sb.matched);
        if (sb.errors == 0 && sb.dump_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end
endmodule
